[rtl/core/multiply_with_carry_lag_rng_assert.svh]
// assertion macros for the lagged multiply-with-carry generator checker
// no dependencies; included by the checker file
`ifndef MULTIPLY_WITH_CARRY_LAG_RNG_ASSERT_SVH
`define MULTIPLY_WITH_CARRY_LAG_RNG_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MWCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MWCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mwcl_pkg.sv]
// shared types and constants of the lagged multiply-with-carry generator
// no dependencies
`timescale 1ns / 1ps

package mwcl_pkg;

    localparam int C_NCELLS   = 8;
    localparam int C_LAG_W    = 16;
    localparam int C_WEIGHT_W = 14;
    localparam int C_SUM_W    = 32;

    typedef logic [C_WEIGHT_W-1:0] t_weight;
    typedef logic [C_LAG_W-1:0]    t_lag;
    typedef logic [C_SUM_W-1:0]    t_sum;

    // weights applied to lags 2..9 (old lags 1..8)
    localparam t_weight C_W_FIRST [C_NCELLS] = '{
        14'd1941, 14'd1860, 14'd1812, 14'd1776,
        14'd1492, 14'd1215, 14'd1066, 14'd12013
    };
    localparam t_weight C_W_SECOND [C_NCELLS] = '{
        14'd1111, 14'd2222, 14'd3333, 14'd4444,
        14'd5555, 14'd6666, 14'd7777, 14'd9272
    };

    localparam logic [14:0] C_SEED_MULT = 15'd30903;
    localparam logic [31:0] C_ZERO_SEED = 32'd123459876;

    // per-cycle shift control of the lag cells
    typedef struct packed {
        logic shift_fwd;   // generate: lag k takes lag k-1
        logic rev_first;   // seeding: first generator lags move down one cell
        logic rev_second;  // seeding: second generator lags move down one cell
    } t_cell_ctl;

endpackage

[rtl/core/mwcl_if.sv]
// valid/ready channel interfaces of the lagged multiply-with-carry generator
// no dependencies
`timescale 1ns / 1ps

interface mwcl_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] seed;

    modport source (output valid, output func, output seed, input ready);
    modport sink   (input valid, input func, input seed, output ready);
endinterface

interface mwcl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

[rtl/core/multiply_with_carry_lag_rng.sv]
// channel      dir  payload                 handshake
// i_in         in   func, seed[31:0]        valid / ready
// o_out        out  random_word[31:0]       valid / ready
//
// a generate word runs from acceptance while the partial sums pass the eight lag cells,
// then writes back, then returns to idle before the next acceptance;
// a seed word runs 18 chained multiply-add steps, then returns to idle
// reset clears the lags, carries and control; a result waits in the output
// register and a following generate holds at write-back until it is taken
// top level; uses mwcl_pkg, mwcl_if, mwcl_cell
`timescale 1ns / 1ps

module multiply_with_carry_lag_rng (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mwcl_in_if.sink      i_in,
    mwcl_out_if.source   o_out
);
    import mwcl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_SEED = 2'd2;

    localparam logic [4:0] C_GEN_LAST    = 5'(C_NCELLS);
    localparam logic [4:0] C_SEED_FIRST_END = 5'(C_NCELLS);
    localparam logic [4:0] C_SEED_CARRY2 = 5'(C_NCELLS + 1);
    localparam logic [4:0] C_SEED_LAST   = 5'(2 * C_NCELLS + 1);

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_num, n_num;
    t_lag        r_carry_first, n_carry_first;
    t_lag        r_carry_second, n_carry_second;
    t_lag        r_lag9_first, n_lag9_first;
    t_lag        r_lag9_second, n_lag9_second;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_word, n_word;

    t_cell_ctl   ctl;
    t_lag        lag_first [C_NCELLS];
    t_lag        lag_second [C_NCELLS];
    t_sum        psum_first [C_NCELLS];
    t_sum        psum_second [C_NCELLS];
    t_sum        acc_first, acc_second;

    logic        in_acc;
    logic [31:0] seed_eff;
    logic [30:0] seed_prod;
    logic [31:0] step_num;
    t_lag        step_x;

    assign in_acc     = i_in.valid && i_in.ready;
    assign seed_eff   = (i_in.seed == '0) ? C_ZERO_SEED : i_in.seed;
    assign seed_prod  = 31'(r_num[15:0]) * 31'(C_SEED_MULT);
    assign step_num   = {1'b0, seed_prod} + {16'b0, r_num[31:16]};
    assign step_x     = step_num[15:0];
    assign acc_first  = psum_first[C_NCELLS-1];
    assign acc_second = psum_second[C_NCELLS-1];

    genvar k;
    generate
        for (k = 0; k < C_NCELLS; k++) begin : g_cell
            t_lag fwd_first, fwd_second, rev_first, rev_second;
            t_sum pin_first, pin_second;

            if (k == 0) begin : g_head
                assign fwd_first  = acc_first[15:0];
                assign fwd_second = acc_second[15:0];
                assign pin_first  = {16'b0, r_carry_first};
                assign pin_second = {16'b0, r_carry_second};
            end else begin : g_body
                assign fwd_first  = lag_first[k-1];
                assign fwd_second = lag_second[k-1];
                assign pin_first  = psum_first[k-1];
                assign pin_second = psum_second[k-1];
            end

            if (k == C_NCELLS - 1) begin : g_tail
                assign rev_first  = step_x;
                assign rev_second = step_x;
            end else begin : g_inner
                assign rev_first  = lag_first[k+1];
                assign rev_second = lag_second[k+1];
            end

            mwcl_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_fwd_first   (fwd_first),
                .i_fwd_second  (fwd_second),
                .i_rev_first   (rev_first),
                .i_rev_second  (rev_second),
                .i_psum_first  (pin_first),
                .i_psum_second (pin_second),
                .o_lag_first   (lag_first[k]),
                .o_lag_second  (lag_second[k]),
                .o_psum_first  (psum_first[k]),
                .o_psum_second (psum_second[k])
            );
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_num          = r_num;
        n_carry_first  = r_carry_first;
        n_carry_second = r_carry_second;
        n_lag9_first   = r_lag9_first;
        n_lag9_second  = r_lag9_second;
        n_out_valid    = r_out_valid;
        n_word         = r_word;
        ctl            = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cnt = '0;
                    if (i_in.func) begin
                        n_state = S_SEED;
                        n_num   = {1'b0, seed_eff[30:0]};
                    end else begin
                        n_state = S_GEN;
                    end
                end
            end
            S_GEN: begin
                if (r_cnt != C_GEN_LAST) begin
                    n_cnt = r_cnt + 5'd1;
                end else if (!r_out_valid || o_out.ready) begin
                    // shift lags, new carry from the high half, new lag 1 from the low
                    ctl.shift_fwd  = 1'b1;
                    n_lag9_first   = lag_first[C_NCELLS-1];
                    n_lag9_second  = lag_second[C_NCELLS-1];
                    n_carry_first  = acc_first[31:16];
                    n_carry_second = acc_second[31:16];
                    n_word         = {acc_first[15:0], acc_second[15:0]};
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SEED: begin
                n_num = step_num;
                // carries are masked to 15 bits as they are written
                priority if (r_cnt == '0) begin
                    n_carry_first = {1'b0, step_x[14:0]};
                end else if (r_cnt <= C_SEED_FIRST_END) begin
                    ctl.rev_first = 1'b1;
                end else if (r_cnt == C_SEED_CARRY2) begin
                    n_carry_second = {1'b0, step_x[14:0]};
                end else begin
                    ctl.rev_second = 1'b1;
                end
                if (r_cnt == C_SEED_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_carry_first  <= '0;
            r_carry_second <= '0;
            r_lag9_first   <= '0;
            r_lag9_second  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_carry_first  <= n_carry_first;
            r_carry_second <= n_carry_second;
            r_lag9_first   <= n_lag9_first;
            r_lag9_second  <= n_lag9_second;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_word <= n_word;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.random_word = r_word;

endmodule

[rtl/core/mwcl_cell.sv]
// one lag cell: holds lag k of both generators and adds its weighted term
// to the partial sums passed along the chain; uses mwcl_pkg
`timescale 1ns / 1ps

module mwcl_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwcl_pkg::t_cell_ctl i_ctl,
    input  mwcl_pkg::t_lag     i_fwd_first,
    input  mwcl_pkg::t_lag     i_fwd_second,
    input  mwcl_pkg::t_lag     i_rev_first,
    input  mwcl_pkg::t_lag     i_rev_second,
    input  mwcl_pkg::t_sum     i_psum_first,
    input  mwcl_pkg::t_sum     i_psum_second,
    output mwcl_pkg::t_lag     o_lag_first,
    output mwcl_pkg::t_lag     o_lag_second,
    output mwcl_pkg::t_sum     o_psum_first,
    output mwcl_pkg::t_sum     o_psum_second
);
    import mwcl_pkg::*;

    localparam int PROD_W = C_LAG_W + C_WEIGHT_W;

    t_lag              r_lag_first, n_lag_first;
    t_lag              r_lag_second, n_lag_second;
    t_sum              r_psum_first, r_psum_second;
    logic [PROD_W-1:0] prod_first, prod_second;

    assign prod_first  = PROD_W'(r_lag_first) * PROD_W'(C_W_FIRST[IDX]);
    assign prod_second = PROD_W'(r_lag_second) * PROD_W'(C_W_SECOND[IDX]);

    always_comb begin
        n_lag_first  = r_lag_first;
        n_lag_second = r_lag_second;
        priority if (i_ctl.shift_fwd) begin
            n_lag_first  = i_fwd_first;
            n_lag_second = i_fwd_second;
        end else begin
            if (i_ctl.rev_first) begin
                n_lag_first = i_rev_first;
            end
            if (i_ctl.rev_second) begin
                n_lag_second = i_rev_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_first  <= '0;
            r_lag_second <= '0;
        end else begin
            r_lag_first  <= n_lag_first;
            r_lag_second <= n_lag_second;
        end
    end

    // partial sums run every cycle; settled once the lags have held for a full pass
    always_ff @(posedge i_clk) begin
        r_psum_first  <= i_psum_first + {{(C_SUM_W-PROD_W){1'b0}}, prod_first};
        r_psum_second <= i_psum_second + {{(C_SUM_W-PROD_W){1'b0}}, prod_second};
    end

    assign o_lag_first   = r_lag_first;
    assign o_lag_second  = r_lag_second;
    assign o_psum_first  = r_psum_first;
    assign o_psum_second = r_psum_second;

endmodule

[rtl/core/mwcl_checker.sv]
// port-level checks of the lagged multiply-with-carry generator, bound to the top
// uses multiply_with_carry_lag_rng_assert.svh
`timescale 1ns / 1ps
`include "multiply_with_carry_lag_rng_assert.svh"

module mwcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_func,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // the input side is not ready again straight after a word is accepted
    `MWCL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !i_in_ready, "input taken back to back")

    // a new word only appears after the input side has been busy
    `MWCL_ASSERT_IMP(a_word_after_work, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "word appeared without work")

    // seeding gives no word
    `MWCL_ASSERT_NEXT(a_seed_silent, i_clk, i_rst_n, in_acc && i_in_func && !i_out_valid, !i_out_valid, "seed produced a word")

    `MWCL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "stalled word changed")

endmodule

bind multiply_with_carry_lag_rng mwcl_checker u_mwcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.random_word)
);
